/* rtl/core/bfba_pkg.sv */
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and codes for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_NOFIT = 2'd1;
	localparam status_t ST_BAD   = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam int unsigned DISK_W      = 9;
	localparam int unsigned COUNT_W     = 9;
	localparam int unsigned START_W     = 8;
	localparam logic [DISK_W-1:0] DISK_RESET = 9'd256;

endpackage

/* rtl/core/bfba_ram.sv */
// ----------------------------------------------------------------------------
// bfba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfba_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/best_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// Best-fit contiguous run allocator over a one-bit-per-block used map.
// ----------------------------------------------------------------------------
// The used map lives in a one-bit-wide RAM and is walked bit-serially, one
// block per cycle, through the RAM read port. After reset a clearing pass
// writes every entry free with in_stall high; configuration writes are
// taken during it. An allocate scans the first L blocks
// (L = min(disk_blocks, NUM_BLOCKS)), marks the chosen run used one block
// at a time and then hands over the result. A free marks its range free one
// block at a time; a rejected request goes straight to the result.
// One request is in work at a time; a new beat is taken while the previous
// result still waits on out.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top
	import bfba_pkg::*;
#(
	parameter int unsigned NUM_BLOCKS = 256
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_wr_en,
	input  logic [DISK_W-1:0]  cfg_wr_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [COUNT_W-1:0] block_count,
	input  logic [START_W-1:0] free_first,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [7:0]         run_start
);

	localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
	localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]         state_q;
	logic [DISK_W-1:0]  disk_q;
	logic [CNT_W-1:0]   lim;
	logic [CNT_W-1:0]   lim_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] rem_q;
	logic [IDX_W-1:0]   ptr_q;
	logic               wr_val_q;

	// scan issue side
	logic [CNT_W-1:0]   scan_q;
	logic               issue_done_q;
	// scan data side, registered alongside the read data
	logic               vld_s1;
	logic               last_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [CNT_W-1:0]   cur_len_q;
	logic [IDX_W-1:0]   cur_start_q;
	logic               have_q;
	logic [CNT_W-1:0]   best_len_q;
	logic [IDX_W-1:0]   best_start_q;

	status_t            res_status_q;
	logic [IDX_W-1:0]   res_start_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [7:0]         run_start_q;

	logic               ram_we;
	logic               ram_wdata;
	logic               ram_re;
	logic               ram_rdata;

	logic               in_beat;
	logic               resp_load;
	logic               blk_free;
	logic               cand;
	logic               fin_have;
	logic [IDX_W-1:0]   fin_start;
	logic               range_bad;

	always_comb begin
		if (32'(disk_q) > 32'(NUM_BLOCKS)) begin
			lim = CNT_W'(NUM_BLOCKS);
		end else begin
			lim = CNT_W'(disk_q);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign range_bad = (32'(free_first) + 32'(block_count)) > 32'(lim);

	// result register loads when empty or when its beat leaves this cycle
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// run tracker: closing a run at a used block or at the end of the disk
	assign blk_free  = !last_s1 && !ram_rdata;
	assign cand      = (32'(cur_len_q) >= 32'(cnt_q)) &&
	                   (!have_q || (cur_len_q < best_len_q));
	assign fin_have  = have_q || cand;
	assign fin_start = cand ? cur_start_q : best_start_q;

	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign ram_wdata = (state_q == S_WRITE) ? wr_val_q : 1'b0;
	assign ram_re    = (state_q == S_SCAN) && !issue_done_q;

	bfba_ram #(
		.WIDTH (1),
		.DEPTH (NUM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q <= DISK_RESET;
		end else if (cfg_wr_en) begin
			disk_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			rem_q        <= '0;
			scan_q       <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			have_q       <= 1'b0;
			cur_len_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (ptr_q == IDX_W'(NUM_BLOCKS - 1)) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end

				S_IDLE: begin
					if (in_beat) begin
						lim_q        <= lim;
						cnt_q        <= block_count;
						rem_q        <= block_count;
						res_start_q  <= '0;
						scan_q       <= '0;
						issue_done_q <= 1'b0;
						vld_s1       <= 1'b0;
						have_q       <= 1'b0;
						cur_len_q    <= '0;
						if (block_count == '0) begin
							res_status_q <= ST_BAD;
							state_q      <= S_RESP;
						end else if (op == OP_FREE) begin
							if (range_bad) begin
								res_status_q <= ST_BAD;
								state_q      <= S_RESP;
							end else begin
								res_status_q <= ST_OK;
								ptr_q        <= IDX_W'(free_first);
								wr_val_q     <= 1'b0;
								state_q      <= S_WRITE;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					// the last data cycle always falls after the last issue
					if (!issue_done_q) begin
						vld_s1  <= 1'b1;
						idx_s1  <= scan_q[IDX_W-1:0];
						last_s1 <= (scan_q == lim_q);
						scan_q  <= scan_q + 1'b1;
						if (scan_q == lim_q) begin
							issue_done_q <= 1'b1;
						end
					end else begin
						vld_s1 <= 1'b0;
					end

					if (vld_s1) begin
						if (blk_free) begin
							if (cur_len_q == '0) begin
								cur_start_q <= idx_s1;
							end
							cur_len_q <= cur_len_q + 1'b1;
						end else begin
							if (cand) begin
								have_q       <= 1'b1;
								best_start_q <= cur_start_q;
								best_len_q   <= cur_len_q;
							end
							cur_len_q <= '0;
						end

						if (last_s1) begin
							if (fin_have) begin
								res_status_q <= ST_OK;
								res_start_q  <= fin_start;
								ptr_q        <= fin_start;
								wr_val_q     <= 1'b1;
								state_q      <= S_WRITE;
							end else begin
								res_status_q <= ST_NOFIT;
								state_q      <= S_RESP;
							end
						end
					end
				end

				S_WRITE: begin
					ptr_q <= ptr_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					if (rem_q == COUNT_W'(1)) begin
						state_q <= S_RESP;
					end
				end

				S_RESP: begin
					if (resp_load) begin
						status_q    <= res_status_q;
						run_start_q <= 8'(res_start_q);
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign run_start = run_start_q;

	// only a successful allocate reports a start block
	a_start_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (run_start == 8'd0))
		else $error("run_start set on a failed request");

	// no beat is taken before the clearing pass is over
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> in_stall)
		else $error("input taken during clearing pass");

	// a write sweep always has blocks left to touch
	a_write_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (rem_q != '0))
		else $error("write sweep with no blocks left");

	// an accepted beat always leaves idle on the next edge
	a_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q != S_IDLE))
		else $error("accepted beat did not start work");

endmodule

/* tb/sv/best_fit_block_allocator_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top_tb
// Self-checking bench for the best-fit block allocator. Requests are driven
// on the falling edge, and a scoreboard keeps its own copy of the used map.
// At every accepted request beat it works out the grant that should come
// back, and it checks each result beat in order. The run covers the edge
// cases, the disk size extremes, random alloc/free traffic and long output
// holds.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top_tb;
	import bfba_pkg::*;

	localparam int NB          = 256;
	localparam int HOLD_CYCLES = 500;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int TAIL_CYCLES = 600;

	typedef struct packed {
		status_t    st;
		logic [7:0] first;
	} grant_t;

	typedef struct {
		int first;
		int len;
	} run_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [DISK_W-1:0]  cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic               op;
	logic [COUNT_W-1:0] block_count;
	logic [START_W-1:0] free_first;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [7:0]         run_start;

	// scoreboard copy of the allocator state
	bit [NB-1:0]       used_map;
	logic [DISK_W-1:0] disk_cfg;
	grant_t            pending_grants[$];
	run_t              live_runs[$];

	int  n_errors;
	int  cycle_cnt;
	bit  idle_on;
	int  hold_req;
	int  hold_seen;
	int  hold_left;
	int  stall_left;

	best_fit_block_allocator_top #(
		.NUM_BLOCKS(NB)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.block_count(block_count),
		.free_first (free_first),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.run_start  (run_start)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("best_fit_block_allocator_top verification failed");
			$finish;
		end
	end

	// best-fit grant for one request beat; updates the used map
	function automatic grant_t predict_grant(input logic op_i, input logic [COUNT_W-1:0] cnt,
			input logic [START_W-1:0] first);
		grant_t g;
		int lim;
		int cur_s;
		int cur_l;
		int best_s;
		int best_l;
		bit have;
		run_t r;
		g.st    = ST_OK;
		g.first = '0;
		lim     = (int'(disk_cfg) > NB) ? NB : int'(disk_cfg);
		if (op_i == OP_ALLOC) begin
			if (cnt == 0) begin
				g.st = ST_BAD;
			end else begin
				cur_s  = 0;
				cur_l  = 0;
				best_s = 0;
				best_l = 0;
				have   = 1'b0;
				// one step past the limit closes the last open run
				for (int i = 0; i <= lim; i++) begin
					if (i < lim && !used_map[i]) begin
						if (cur_l == 0)
							cur_s = i;
						cur_l++;
					end else begin
						if (cur_l >= int'(cnt) && (!have || cur_l < best_l)) begin
							have   = 1'b1;
							best_s = cur_s;
							best_l = cur_l;
						end
						cur_l = 0;
					end
				end
				if (!have) begin
					g.st = ST_NOFIT;
				end else begin
					for (int i = 0; i < int'(cnt); i++)
						used_map[best_s + i] = 1'b1;
					g.first = best_s[7:0];
					r.first = best_s;
					r.len   = int'(cnt);
					live_runs.push_back(r);
				end
			end
		end else begin
			if (cnt == 0 || int'(first) + int'(cnt) > lim) begin
				g.st = ST_BAD;
			end else begin
				for (int i = 0; i < int'(cnt); i++)
					used_map[int'(first) + i] = 1'b0;
			end
		end
		return g;
	endfunction

	always @(posedge clk) begin : scoreboard
		grant_t got;
		grant_t want;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				got.st    = status;
				got.first = run_start;
				if (pending_grants.size() == 0) begin
					n_errors++;
					if (n_errors < 50)
						$error("result beat with nothing expected: status %0d run_start %0d",
							got.st, got.first);
				end else begin
					want = pending_grants.pop_front();
					if (got.st !== want.st) begin
						n_errors++;
						if (n_errors < 50)
							$error("status mismatch: expected %0d actual %0d", want.st, got.st);
					end
					if (got.first !== want.first) begin
						n_errors++;
						if (n_errors < 50)
							$error("run_start mismatch: expected %0d actual %0d",
								want.first, got.first);
					end
				end
			end
			if (cfg_wr_en)
				disk_cfg = cfg_wr_data;
			if (in_valid === 1'b1 && in_stall === 1'b0)
				pending_grants.push_back(predict_grant(op, block_count, free_first));
		end
	end

	// receiver: random stall bursts, plus a long hold on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall = 1'b1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 12);
			out_stall  = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// one request beat; valid stays high for a following beat unless a gap comes first
	task automatic issue_request(input logic op_i, input int cnt, input int first);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		op          = op_i;
		block_count = cnt[COUNT_W-1:0];
		free_first  = first[START_W-1:0];
		in_valid    = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_disk_blocks(input int value);
		wait_drained();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value[DISK_W-1:0];
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	function automatic int pick_alloc_count();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return $urandom_range(1, 8);
		else if (p < 80)
			return $urandom_range(9, 40);
		else if (p < 92)
			return $urandom_range(41, 128);
		else if (p < 97)
			return $urandom_range(129, 256);
		return 0;
	endfunction

	// mostly alloc and free of live runs, some noise requests
	task automatic issue_random_request();
		int pick;
		int idx;
		int cnt;
		run_t r;
		pick = $urandom_range(0, 99);
		if (live_runs.size() == 0 || pick < 45) begin
			issue_request(OP_ALLOC, pick_alloc_count(), $urandom_range(0, 255));
		end else if (pick < 85) begin
			idx = $urandom_range(0, live_runs.size() - 1);
			r   = live_runs[idx];
			live_runs.delete(idx);
			issue_request(OP_FREE, r.len, r.first);
		end else begin
			cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 256);
			issue_request(1'($urandom_range(0, 1)), cnt, $urandom_range(0, 255));
		end
	endtask

	// new disk size, then clear the usable part so the phase starts empty
	task automatic start_phase(input int disk);
		int lim;
		write_disk_blocks(disk);
		lim = (disk > NB) ? NB : disk;
		if (lim > 0)
			issue_request(OP_FREE, lim, 0);
		live_runs.delete();
	endtask

	task automatic test_reject_and_whole_disk();
		idle_on = 1'b1;
		issue_request(OP_ALLOC, 0, 0);
		issue_request(OP_FREE, 0, 17);
		issue_request(OP_ALLOC, 256, 255);
		issue_request(OP_ALLOC, 1, 0);
		issue_request(OP_FREE, 256, 0);
		issue_request(OP_FREE, 2, 255);
		issue_request(OP_FREE, 1, 255);
	endtask

	task automatic test_best_fit_choice();
		issue_request(OP_ALLOC, 10, 0);
		issue_request(OP_ALLOC, 5, 0);
		issue_request(OP_ALLOC, 10, 0);
		issue_request(OP_ALLOC, 3, 0);
		// two holes of ten at 0 and 15, big tail from 28
		issue_request(OP_FREE, 10, 0);
		issue_request(OP_FREE, 10, 15);
		issue_request(OP_ALLOC, 10, 0);
		issue_request(OP_ALLOC, 4, 0);
		issue_request(OP_FREE, 256, 0);
		live_runs.delete();
	endtask

	task automatic test_disk_size_limits();
		write_disk_blocks(0);
		issue_request(OP_ALLOC, 1, 0);
		issue_request(OP_FREE, 1, 0);
		write_disk_blocks(511);
		issue_request(OP_ALLOC, 256, 0);
		issue_request(OP_FREE, 256, 0);
		write_disk_blocks(1);
		issue_request(OP_ALLOC, 2, 0);
		issue_request(OP_ALLOC, 1, 0);
		issue_request(OP_FREE, 2, 0);
		issue_request(OP_FREE, 1, 0);
		write_disk_blocks(300);
		issue_request(OP_FREE, 57, 200);
		issue_request(OP_FREE, 56, 200);
		write_disk_blocks(int'(DISK_RESET));
		live_runs.delete();
	endtask

	task automatic run_traffic(input int disk, input int n);
		start_phase(disk);
		for (int i = 0; i < n; i++) begin
			if (i % 30 == 0)
				idle_on = ($urandom_range(0, 4) != 0);
			issue_random_request();
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(256, 110);
		run_traffic(37, 70);
		run_traffic($urandom_range(2, 255), 70);
		run_traffic(511, 60);
		run_traffic(1, 20);
	endtask

	task automatic test_output_backpressure();
		start_phase(256);
		idle_on = 1'b0;
		hold_req++;
		repeat (20) issue_random_request();
	endtask

	task automatic test_drain_pause();
		idle_on = 1'b1;
		repeat (15) issue_random_request();
		wait_drained();
		repeat (15) issue_random_request();
	endtask

	task automatic test_back_to_back();
		start_phase(256);
		idle_on = 1'b0;
		repeat (80) issue_random_request();
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		op          = OP_ALLOC;
		block_count = '0;
		free_first  = '0;
		out_stall   = 1'b0;
		used_map    = '0;
		disk_cfg    = DISK_RESET;
		n_errors    = 0;
		cycle_cnt   = 0;
		idle_on     = 1'b0;
		hold_req    = 0;
		hold_seen   = 0;
		hold_left   = 0;
		stall_left  = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reject_and_whole_disk();
		test_best_fit_choice();
		test_disk_size_limits();
		test_random_traffic();
		test_output_backpressure();
		test_drain_pause();
		test_back_to_back();

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (n_errors == 0)
			$display("best_fit_block_allocator_top verification clean");
		else
			$display("best_fit_block_allocator_top verification failed");
		$finish;
	end

endmodule
